// File: hw/rtl/plst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_pkg: shared definitions for the positional list store
// Sizes, operation codes and status codes used by the store and its bench.
// ----------------------------------------------------------------------------
package plst_pkg;

    // store geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int CMP_W    = POS_W + CNT_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

// File: hw/rtl/plst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/positional_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store: ordered list with insert, read-at and find
// Entries live in a single RAM; one index counter with a shared +/-1 adder
// and one 32-bit comparator walk the list under a small sequencer.
// ----------------------------------------------------------------------------
// Insert shifts entries from position on up a slot, then writes the value; read
// issues the RAM read, then takes the data; find compares from index 0 to a
// match or the end; full, out-of-range or unused ops just finish. Each move or
// compare reads first as the RAM read is registered. One item at a time: busy
// stays high until done, a one-cycle strobe that the receiver cannot stall.
// Reset (rst_n low, async) empties the list; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_list_store (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [plst_pkg::OP_W-1:0]            operation,
    input  logic [plst_pkg::POS_W-1:0]           position,
    input  logic signed [plst_pkg::DATA_W-1:0]   value,
    output logic                                 done,
    output logic signed [plst_pkg::DATA_W-1:0]   read_value,
    output logic [plst_pkg::CNT_W-1:0]           found_index,
    output logic [plst_pkg::CNT_W-1:0]           entry_count,
    output plst_pkg::status_t                    status
);

    import plst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_WR,
        S_INS,
        S_RD_ISSUE,
        S_RD_DATA,
        S_FIND_RD,
        S_FIND_CMP,
        S_FIN
    } state_t;

    state_t                 state_reg, state_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [DATA_W-1:0]      val_reg, val_next;
    logic [DATA_W-1:0]      rv_reg, rv_next;
    logic [CNT_W-1:0]       fi_reg, fi_next;
    status_t                st_reg, st_next;

    // shared index adder and data comparator
    logic                   idx_down;
    logic [CNT_W-1:0]       idx_adj;
    logic                   data_eq;

    // ram port
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [DATA_W-1:0]      ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [DATA_W-1:0]      ram_rdata;

    // input position against count
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic                   pos_below_cnt;

    assign pos_ext       = CMP_W'(position);
    assign cnt_ext       = CMP_W'(cnt_reg);
    assign pos_below_cnt = pos_ext < cnt_ext;

    assign idx_down = (state_reg == S_SH_RD) || (state_reg == S_SH_WR);
    assign idx_adj  = idx_down ? (idx_reg - CNT_W'(1)) : (idx_reg + CNT_W'(1));
    assign data_eq  = (ram_rdata == val_reg);

    plst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ram access per state
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_SH_RD:
            begin
                ram_raddr = idx_adj[ADDR_W-1:0];
            end
            S_SH_WR:
            begin
                ram_we = 1'b1;
            end
            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[ADDR_W-1:0];
                ram_wdata = val_reg;
            end
            S_RD_ISSUE:
            begin
                ram_raddr = pos_reg[ADDR_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // sequencer next state and results
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        rv_next    = rv_reg;
        fi_next    = fi_reg;
        st_next    = st_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next = value;
                    rv_next  = '0;
                    fi_next  = '0;
                    st_next  = ST_OK;
                    idx_next = cnt_reg;
                    case (operation)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CNT_W'(CAPACITY))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                // positions at or past the end append
                                pos_next   = pos_below_cnt ? CNT_W'(position) : cnt_reg;
                                state_next = pos_below_cnt ? S_SH_RD : S_INS;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_below_cnt)
                            begin
                                pos_next   = CNT_W'(position);
                                state_next = S_RD_ISSUE;
                            end
                            else
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_FIN;
                            end
                        end
                        OP_FIND:
                        begin
                            idx_next   = '0;
                            fi_next    = cnt_reg;
                            state_next = (cnt_reg == '0) ? S_FIN : S_FIND_RD;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                // entry idx-1 moved up to idx
                idx_next   = idx_adj;
                state_next = (idx_adj == pos_reg) ? S_INS : S_SH_RD;
            end
            S_INS:
            begin
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_FIN;
            end
            S_RD_ISSUE:
            begin
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                rv_next    = ram_rdata;
                state_next = S_FIN;
            end
            S_FIND_RD:
            begin
                state_next = S_FIND_CMP;
            end
            S_FIND_CMP:
            begin
                if (data_eq)
                begin
                    fi_next    = idx_reg;
                    state_next = S_FIN;
                end
                else if (idx_adj == cnt_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = idx_adj;
                    state_next = S_FIND_RD;
                end
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            val_reg   <= '0;
            rv_reg    <= '0;
            fi_reg    <= '0;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            val_reg   <= val_next;
            rv_reg    <= rv_next;
            fi_reg    <= fi_next;
            st_reg    <= st_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign read_value  = rv_reg;
    assign found_index = fi_reg;
    assign entry_count = cnt_reg;
    assign status      = st_reg;

    // every accepted transfer keeps the sequencer busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not start the sequencer");

    // result strobe only when idle, never during an item
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobe while busy");

    // count never passes capacity
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // count changes only by one, at an insert
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> ($past(state_reg) == S_INS))
        else $error("entry count changed outside insert");

    // ram writes only during a shift or an insert
    a_ram_we: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> busy)
        else $error("ram write while idle");

endmodule

// File: tb/sv/tb_positional_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_store: self-checking bench for the positional list store
// A directed table walks empty-list, extreme and duplicate cases, then random
// insert/read/find traffic fills the list to capacity and beyond. Every result
// is compared field by field against its typed row or an in-bench list copy.
// ----------------------------------------------------------------------------
module tb_positional_list_store;
    import plst_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CLK_HALF     = 6;
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASE_ITEMS  = 200;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         found_index;
        logic [CNT_W-1:0]         entry_count;
        status_t                  status;
    } list_result_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        logic                     typed;
        list_result_t             res;
    } list_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         found_index;
    logic [CNT_W-1:0]         entry_count;
    status_t                  status;

    // shadow copy of the ordered list
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len = 0;

    list_result_t             pending_q [$];
    int                       error_count = 0;

    // sender idle percentage per random phase
    int                       idle_pct [4] = '{0, 51, 0, 35};

    // directed rows: typed expectations where they are obvious
    list_row_t directed [0:22] = '{
        '{OP_READ,   8'd0,   32'sd0,           1'b1, '{32'sd0, 7'd0, 7'd0, ST_RANGE}},
        '{OP_FIND,   8'd0,   32'sd0,           1'b1, '{32'sd0, 7'd0, 7'd0, ST_OK}},
        '{OP_UNUSED, 8'd0,   32'sd0,           1'b1, '{32'sd0, 7'd0, 7'd0, ST_OK}},
        '{OP_READ,   8'd255, 32'sd0,           1'b1, '{32'sd0, 7'd0, 7'd0, ST_RANGE}},
        '{OP_INSERT, 8'd255, 32'sh7fffffff,    1'b1, '{32'sd0, 7'd0, 7'd1, ST_OK}},
        '{OP_INSERT, 8'd0,   32'sh80000000,    1'b1, '{32'sd0, 7'd0, 7'd2, ST_OK}},
        '{OP_READ,   8'd0,   32'sd0,           1'b1, '{32'sh80000000, 7'd0, 7'd2, ST_OK}},
        '{OP_READ,   8'd1,   32'sd0,           1'b1, '{32'sh7fffffff, 7'd0, 7'd2, ST_OK}},
        '{OP_READ,   8'd2,   32'sd0,           1'b1, '{32'sd0, 7'd0, 7'd2, ST_RANGE}},
        '{OP_INSERT, 8'd1,   -32'sd1,          1'b1, '{32'sd0, 7'd0, 7'd3, ST_OK}},
        '{OP_INSERT, 8'd3,   32'sd0,           1'b1, '{32'sd0, 7'd0, 7'd4, ST_OK}},
        '{OP_FIND,   8'd0,   -32'sd1,          1'b1, '{32'sd0, 7'd1, 7'd4, ST_OK}},
        '{OP_FIND,   8'd0,   32'sh12345678,    1'b1, '{32'sd0, 7'd4, 7'd4, ST_OK}},
        '{OP_INSERT, 8'd2,   -32'sd1,          1'b1, '{32'sd0, 7'd0, 7'd5, ST_OK}},
        '{OP_FIND,   8'd0,   -32'sd1,          1'b0, '{32'sd0, 7'd0, 7'd0, ST_OK}},
        '{OP_READ,   8'd4,   32'sd0,           1'b1, '{32'sd0, 7'd0, 7'd5, ST_OK}},
        '{OP_UNUSED, 8'd255, -32'sd1,          1'b1, '{32'sd0, 7'd0, 7'd5, ST_OK}},
        '{OP_READ,   8'd255, 32'sd0,           1'b1, '{32'sd0, 7'd0, 7'd5, ST_RANGE}},
        '{OP_FIND,   8'd0,   32'sd0,           1'b0, '{32'sd0, 7'd0, 7'd0, ST_OK}},
        '{OP_INSERT, 8'd128, 32'sh55555555,    1'b1, '{32'sd0, 7'd0, 7'd6, ST_OK}},
        '{OP_INSERT, 8'd0,   32'shaaaaaaaa,    1'b1, '{32'sd0, 7'd0, 7'd7, ST_OK}},
        '{OP_READ,   8'd6,   32'sd0,           1'b0, '{32'sd0, 7'd0, 7'd0, ST_OK}},
        '{OP_FIND,   8'd0,   32'sh7fffffff,    1'b0, '{32'sd0, 7'd0, 7'd0, ST_OK}}
    };

    positional_list_store dut (
        .clk,
        .rst_n,
        .start,
        .busy,
        .operation,
        .position,
        .value,
        .done,
        .read_value,
        .found_index,
        .entry_count,
        .status
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // mismatch reporting
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // apply one operation to the shadow list and return its result
    task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                 input logic signed [DATA_W-1:0] val,
                                 output list_result_t res);
        int slot;
        res = '{32'sd0, '0, '0, ST_OK};
        case (op)
            OP_INSERT:
            begin
                if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    // position past the end appends
                    slot = (int'(pos) > list_len) ? list_len : int'(pos);
                    for (int i = list_len; i > slot; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[slot] = val;
                    list_len++;
                end
            end
            OP_READ:
            begin
                if (int'(pos) < list_len)
                    res.read_value = list_mem[pos[ADDR_W-1:0]];
                else
                    res.status = ST_RANGE;
            end
            OP_FIND:
            begin
                // first match wins, count when absent
                res.found_index = CNT_W'(list_len);
                for (int i = list_len - 1; i >= 0; i--)
                    if (list_mem[i] == val)
                        res.found_index = CNT_W'(i);
            end
            default: ;
        endcase
        res.entry_count = CNT_W'(list_len);
    endtask

    // drive one command and hold it until the transfer happens
    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic signed [DATA_W-1:0] val, input logic typed,
                             input list_result_t typed_res);
        list_result_t predicted;
        start     <= 1'b1;
        operation <= op;
        position  <= pos;
        value     <= val;
        do
            @(posedge clk);
        while (busy);
        apply_list_op(op, pos, val, predicted);
        pending_q.push_back(typed ? typed_res : predicted);
    endtask

    // random sender gaps
    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop sending until every pending result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    // value source: stored entries, small values for duplicates, extremes, random
    function automatic logic signed [DATA_W-1:0] pick_value(input int stored_pct);
        int r;
        r = $urandom_range(99);
        if (r < stored_pct && list_len > 0)
            return list_mem[$urandom_range(list_len - 1)];
        if (r < stored_pct + 20)
            return $urandom_range(4) - 2;
        if (r < stored_pct + 25)
            return ($urandom_range(1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        return $urandom;
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_result
        list_result_t want;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
                report_mismatch($sformatf("result with none pending: count=%0d status=%0d",
                                          entry_count, status));
            else
            begin
                want = pending_q.pop_front();
                if (read_value !== want.read_value)
                    report_mismatch($sformatf("read_value got %h want %h",
                                              read_value, want.read_value));
                if (found_index !== want.found_index)
                    report_mismatch($sformatf("found_index got %0d want %0d",
                                              found_index, want.found_index));
                if (entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              entry_count, want.entry_count));
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              status, want.status));
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        list_result_t             no_res;
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int                       r;
        int                       sel;
        no_res    = '{32'sd0, '0, '0, ST_OK};
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = OP_INSERT;
        position  = '0;
        value     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed[i])
            send_item(directed[i].op, directed[i].pos, directed[i].val,
                      directed[i].typed, directed[i].res);

        // random traffic in idle phases, fully drained at each boundary
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
                wait_drained();
            idle_gap(idle_pct[n / PHASE_ITEMS]);
            r = $urandom_range(99);
            if (r < 3)
                op = OP_UNUSED;
            else if (r < 20)
                op = OP_INSERT;
            else if (r < 60)
                op = OP_READ;
            else
                op = OP_FIND;
            sel = $urandom_range(9);
            case (op)
                OP_INSERT:
                begin
                    if (sel < 3)
                        pos = POS_W'($urandom_range(255));
                    else if (sel < 5)
                        pos = POS_W'(list_len);
                    else if (sel == 5)
                        pos = '0;
                    else
                        pos = POS_W'($urandom_range(list_len));
                    val = pick_value(30);
                end
                OP_READ:
                begin
                    if (sel < 2)
                        pos = POS_W'($urandom_range(255));
                    else if (sel == 2)
                        pos = POS_W'(list_len);
                    else if (sel == 3 && list_len > 0)
                        pos = POS_W'(list_len - 1);
                    else
                        pos = POS_W'($urandom_range(list_len));
                    val = $urandom;
                end
                OP_FIND:
                begin
                    pos = POS_W'($urandom_range(255));
                    val = pick_value(50);
                end
                default:
                begin
                    pos = POS_W'($urandom_range(255));
                    val = $urandom;
                end
            endcase
            send_item(op, pos, val, 1'b0, no_res);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_positional_list_store: done, clean");
        else
            $display("tb_positional_list_store: done, errors");
        $finish;
    end

    // run limit
    initial
    begin : watchdog
        #20_000_000;
        $display("tb_positional_list_store: done, errors");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/plst_pkg.sv
hw/rtl/plst_ram.sv
hw/rtl/positional_list_store.sv
tb/sv/tb_positional_list_store.sv
